// File: rtl/pcbe_pkg.sv
`timescale 1ns / 1ps

package pcbe_pkg;

   // Fixed formats of the request and result fields
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int POS_WIDTH   = 22;
   localparam int SEG_WIDTH   = POS_WIDTH - FRAC_BITS;
   localparam int INDEX_WIDTH = 6;
   localparam int COUNT_WIDTH = 7;
   localparam int AXES        = 3;
   localparam int DEF_MAX_POINTS = 64;

   // Internal datapath: coefficients and Horner sums are carried 12 bits wider than a coordinate
   localparam int INT_WIDTH  = COORD_WIDTH + 12;
   localparam int PROD_WIDTH = INT_WIDTH + FRAC_BITS + 1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [AXES-1:0][COORD_WIDTH-1:0] triple_type;

   typedef struct packed {
      logic                   mode;
      logic [INDEX_WIDTH-1:0] point_index;
      coord_type              anchor_x;
      coord_type              anchor_y;
      coord_type              anchor_z;
      coord_type              handle_in_x;
      coord_type              handle_in_y;
      coord_type              handle_in_z;
      coord_type              handle_out_x;
      coord_type              handle_out_y;
      coord_type              handle_out_z;
      logic [POS_WIDTH-1:0]   curve_position;
   } req_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
   } rsp_type;

   // One table entry, axis 0 is x
   typedef struct packed {
      triple_type anchor;
      triple_type handle_in;
      triple_type handle_out;
   } point_type;

   // Per-request control handed to every lane alongside the table data
   typedef struct packed {
      logic                 clamp;
      logic                 empty;
      logic [FRAC_BITS-1:0] frac;
   } lane_ctl_type;

endpackage

// File: rtl/pcbe_ram.sv
`timescale 1ns / 1ps

module pcbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read two with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: rtl/pcbe_lane.sv
`timescale 1ns / 1ps

module pcbe_lane import pcbe_pkg::*; (
   input  logic         clock,
   input  coord_type    p0,
   input  coord_type    h0,
   input  coord_type    h1,
   input  coord_type    p1,
   input  lane_ctl_type ctl,
   output coord_type    result
);

   typedef logic signed [INT_WIDTH-1:0]  int_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   function automatic int_type round_frac(prod_type prod);
      prod_type t;
      t = prod + prod_type'(1 << (FRAC_BITS - 1));
      return t[FRAC_BITS+INT_WIDTH-1:FRAC_BITS];
   endfunction

   int_type p0_w, h0_w, h1_w, p1_w;
   int_type c_in, b_in, a_in, p0_in, dc, db;
   int_type a1_ff, b1_ff, c1_ff, p1_ff;
   int_type b2_ff, c2_ff, p2_ff;
   int_type c3_ff, p3_ff;
   int_type p4_ff;
   logic [FRAC_BITS-1:0] f1_ff, f2_ff, f3_ff;
   prod_type prod2_ff, prod3_ff, prod4_ff;
   int_type r1, r2, r3;
   int_type max_v, min_v;

   assign p0_w = int_type'(p0);
   assign h0_w = int_type'(h0);
   assign h1_w = int_type'(h1);
   assign p1_w = int_type'(p1);

   // Form the cubic coefficients; clamp and empty collapse to a constant
   always_comb begin
      dc = h0_w - p0_w;
      db = h1_w - h0_w;
      c_in = (dc <<< 1) + dc;
      b_in = (db <<< 1) + db - c_in;
      a_in = p1_w - p0_w - c_in - b_in;
      p0_in = p0_w;
      if (ctl.empty) begin
         a_in = '0; b_in = '0; c_in = '0; p0_in = '0;
      end else if (ctl.clamp) begin
         a_in = '0; b_in = '0; c_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= a_in;
      b1_ff <= b_in;
      c1_ff <= c_in;
      p1_ff <= p0_in;
      f1_ff <= ctl.frac;
   end

   // First Horner product a*f
   always_ff @(posedge clock) begin
      prod2_ff <= prod_type'(a1_ff) * prod_type'({1'b0, f1_ff});
      b2_ff    <= b1_ff;
      c2_ff    <= c1_ff;
      p2_ff    <= p1_ff;
      f2_ff    <= f1_ff;
   end

   // Round, add b, multiply by f again
   assign r1 = round_frac(prod2_ff) + b2_ff;

   always_ff @(posedge clock) begin
      prod3_ff <= prod_type'(r1) * prod_type'({1'b0, f2_ff});
      c3_ff    <= c2_ff;
      p3_ff    <= p2_ff;
      f3_ff    <= f2_ff;
   end

   // Round, add c, last multiply
   assign r2 = round_frac(prod3_ff) + c3_ff;

   always_ff @(posedge clock) begin
      prod4_ff <= prod_type'(r2) * prod_type'({1'b0, f3_ff});
      p4_ff    <= p3_ff;
   end

   // Round, add p0, saturate to the coordinate range
   assign r3    = round_frac(prod4_ff) + p4_ff;
   assign max_v = int_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   assign min_v = -max_v - int_type'(1);

   always_comb begin
      if (r3 > max_v) begin
         result = coord_type'(max_v);
      end else if (r3 < min_v) begin
         result = coord_type'(min_v);
      end else begin
         result = coord_type'(r3);
      end
   end

endmodule

// File: rtl/piecewise_cubic_bezier_eval_unit.sv
`timescale 1ns / 1ps
// An evaluate request taken on start returns its result on rsp_data while rsp_strobe is high.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Loads write the point table through one port; evaluations read it at two addresses.
// Reset clears point_count and the pipeline valid bits; table contents stay undefined.
// Three lanes (x, y, z) each run a registered Horner pipeline; a final register merges them.
module piecewise_cubic_bezier_eval_unit import pcbe_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [COUNT_WIDTH-1:0] csr_write_data
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int DEPTH = 5;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [DEPTH-1:0]       valid_ff;
   rsp_type                rsp_ff;
   lane_ctl_type           ctl_ff, ctl_in;
   point_type              wr_point, pt_a, pt_b;
   logic                   accept, wr_en;
   logic [AW-1:0]          addr_a, addr_b;
   int                     n_pts, seg;
   coord_type [AXES-1:0]   lane_out;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Hold the point count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // Table write for load requests
   assign wr_en = accept && (req_data.mode == MODE_LOAD) &&
                  (int'(req_data.point_index) < MAX_POINTS);
   assign wr_point.anchor     = {req_data.anchor_z, req_data.anchor_y, req_data.anchor_x};
   assign wr_point.handle_in  = {req_data.handle_in_z, req_data.handle_in_y,
                                 req_data.handle_in_x};
   assign wr_point.handle_out = {req_data.handle_out_z, req_data.handle_out_y,
                                 req_data.handle_out_x};

   // Pick segment addresses, clamping past the last point
   always_comb begin
      n_pts = (int'(count_ff) > MAX_POINTS) ? MAX_POINTS : int'(count_ff);
      seg   = int'(req_data.curve_position[POS_WIDTH-1:FRAC_BITS]);
      ctl_in.empty = (n_pts == 0);
      ctl_in.clamp = (seg >= n_pts - 1);
      ctl_in.frac  = req_data.curve_position[FRAC_BITS-1:0];
      addr_a = ctl_in.clamp ? AW'(n_pts - 1) : AW'(seg);
      addr_b = AW'(seg + 1);
   end

   pcbe_ram #(
      .WIDTH ($bits(point_type)),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(req_data.point_index)),
      .wr_data   (wr_point),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (pt_a),
      .rd_data_b (pt_b)
   );

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
   end

   // Advance the valid bits of evaluate requests
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         valid_ff   <= {valid_ff[DEPTH-2:0], accept && (req_data.mode == MODE_EVAL)};
         rsp_strobe <= valid_ff[DEPTH-1];
      end
   end

   for (genvar k = 0; k < AXES; k++) begin : g_lane
      pcbe_lane u_lane (
         .clock  (clock),
         .p0     (coord_type'(pt_a.anchor[k])),
         .h0     (coord_type'(pt_a.handle_out[k])),
         .h1     (coord_type'(pt_b.handle_in[k])),
         .p1     (coord_type'(pt_b.anchor[k])),
         .ctl    (ctl_ff),
         .result (lane_out[k])
      );
   end

   // Merge the lane results into one response
   always_ff @(posedge clock) begin
      rsp_ff.pos_x <= lane_out[0];
      rsp_ff.pos_y <= lane_out[1];
      rsp_ff.pos_z <= lane_out[2];
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/pcbe_checker.sv
`timescale 1ns / 1ps

module pcbe_checker import pcbe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe
);

   // Never hold off requests
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Pipeline drains on reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe after reset");

   // Every evaluate request is answered with a response strobe
   a_eval_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_EVAL) |-> ##6 rsp_strobe)
      else $error("missing response");

   // A load request makes no response
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_LOAD) |-> ##6 !rsp_strobe)
      else $error("response to a load");

   // No response without an evaluate request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_data.mode == MODE_EVAL, 6))
      else $error("spurious response");

endmodule

bind piecewise_cubic_bezier_eval_unit pcbe_checker u_pcbe_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe)
);
